// ===== src/rfdp_pkg.sv =====
// Shared types and constants for the ring FIFO with drop and peek.
// Used by the front, the back and the top level; depends on nothing else.
package rfdp_pkg;

  localparam int unsigned DEPTH_DEFAULT     = 16;
  localparam int unsigned WORD_BITS_DEFAULT = 32;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned IN_DATA_W   = 32;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned OUT_DATA_W  = 32;
  localparam int unsigned OUT_CNT_W   = 5;
  localparam int unsigned CFG_W       = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_DROP = 2'd2,
    OP_PEEK = 2'd3
  } op_e;

  // One decoded command as it travels from the front to the back.
  typedef struct packed {
    op_e                  op;
    logic [IN_DATA_W-1:0] data;
    logic [COUNT_W-1:0]   cnt;
  } cmd_t;

endpackage

// ===== src/rfdp_front.sv =====
// Front end of the ring FIFO: accepts command items, decodes them and holds
// them in a two-entry queue for the back end. Depends on rfdp_pkg.
module rfdp_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_valid_i,
  output logic                                s_ready_o,
  input  logic [rfdp_pkg::IN_TDATA_W-1:0]     s_data_i,
  input  logic [rfdp_pkg::CMD_W-1:0]          s_user_i,
  output logic                                cmd_valid_o,
  input  logic                                cmd_ready_i,
  output rfdp_pkg::cmd_t                      cmd_o
);

  rfdp_pkg::cmd_t entry_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     fill_q, fill_d;
  logic           push, pop;
  rfdp_pkg::cmd_t decoded;

  always_comb begin
    decoded.op   = rfdp_pkg::op_e'(s_user_i);
    decoded.data = s_data_i[rfdp_pkg::IN_DATA_W-1:0];
    decoded.cnt  = s_data_i[rfdp_pkg::IN_DATA_W +: rfdp_pkg::COUNT_W];
  end

  assign s_ready_o   = (fill_q != 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = entry_q[rd_ptr_q];
  assign push        = s_valid_i && s_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q;
    if (push && !pop) begin
      fill_d = fill_q + 2'd1;
    end else if (pop && !push) begin
      fill_d = fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= decoded;
    end
  end

  // The queue never holds more than two items.
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q != 2'd3)
    else $error("front queue fill count out of range");

endmodule

// ===== src/rfdp_back.sv =====
// Back end of the ring FIFO: holds the slot memory, the indexes and the fill
// count, executes one command per cycle while the result is not stalled and
// registers the result. Depends on rfdp_pkg.
module rfdp_back #(
  parameter int unsigned DEPTH     = rfdp_pkg::DEPTH_DEFAULT,
  parameter int unsigned WORD_BITS = rfdp_pkg::WORD_BITS_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rfdp_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  logic                                 cmd_valid_i,
  output logic                                 cmd_ready_o,
  input  rfdp_pkg::cmd_t                       cmd_i,
  output logic                                 m_valid_o,
  input  logic                                 m_ready_i,
  output logic [rfdp_pkg::OUT_TDATA_W-1:0]     m_data_o,
  output logic                                 m_user_o
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > rfdp_pkg::CFG_W) ? CNT_W : rfdp_pkg::CFG_W;

  logic [WORD_BITS-1:0]       mem [DEPTH];
  logic [WORD_BITS-1:0]       rd_word_q;

  logic [rfdp_pkg::CFG_W-1:0] cap_raw_q;
  logic [IDX_W-1:0]           wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0]           rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]           held_q, held_d;

  logic                       out_valid_q;
  logic                       ok_q, ok_d;
  logic                       rd_sel_q, rd_sel_d;
  logic [rfdp_pkg::OUT_CNT_W-1:0] dropped_q, dropped_d;
  logic [rfdp_pkg::OUT_CNT_W-1:0] fill_q, fill_d;
  logic [rfdp_pkg::OUT_CNT_W-1:0] free_q, free_d;

  logic [CMP_W-1:0]           cap_raw_ext, cap_ext, cnt_ext, held_ext;
  logic [CMP_W-1:0]           held_d_ext, free_ext;
  logic [CNT_W-1:0]           cap, cnt_n, drop_n, free_n;
  logic [IDX_W-1:0]           peek_idx, rd_addr;
  logic                       advance, mem_we, mem_re;
  logic [63:0]                din_ext, rd_ext;
  logic [WORD_BITS-1:0]       wr_word;

  // Adds to a ring index; the sum stays below twice the capacity.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] add,
                                                input logic [CNT_W-1:0] lim);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(add);
    if (sum >= (CNT_W + 1)'(lim)) begin
      sum = sum - (CNT_W + 1)'(lim);
    end
    return sum[IDX_W-1:0];
  endfunction

  // A capacity of zero acts as one, anything above the storage depth as the depth.
  always_comb begin
    cap_raw_ext = CMP_W'(cap_raw_q);
    if (cap_raw_ext == '0) begin
      cap_ext = CMP_W'(1);
    end else if (cap_raw_ext > CMP_W'(DEPTH)) begin
      cap_ext = CMP_W'(DEPTH);
    end else begin
      cap_ext = cap_raw_ext;
    end
  end

  assign cap      = cap_ext[CNT_W-1:0];
  assign cnt_ext  = CMP_W'(cmd_i.cnt);
  assign held_ext = CMP_W'(held_q);
  assign cnt_n    = cnt_ext[CNT_W-1:0];
  assign drop_n   = (cnt_ext < held_ext) ? cnt_n : held_q;
  assign peek_idx = wrap_add(rd_idx_q, cnt_n, cap);

  assign cmd_ready_o = !out_valid_q || m_ready_i;
  assign advance     = cmd_valid_i && cmd_ready_o;

  always_comb begin
    wr_idx_d  = wr_idx_q;
    rd_idx_d  = rd_idx_q;
    held_d    = held_q;
    ok_d      = 1'b0;
    rd_sel_d  = 1'b0;
    mem_we    = 1'b0;
    rd_addr   = rd_idx_q;
    dropped_d = '0;
    case (cmd_i.op)
      rfdp_pkg::OP_PUSH: begin
        if (held_q < cap) begin
          mem_we   = 1'b1;
          wr_idx_d = wrap_add(wr_idx_q, CNT_W'(1), cap);
          held_d   = held_q + CNT_W'(1);
          ok_d     = 1'b1;
        end
      end
      rfdp_pkg::OP_POP: begin
        if (held_q != '0) begin
          rd_sel_d = 1'b1;
          rd_idx_d = wrap_add(rd_idx_q, CNT_W'(1), cap);
          held_d   = held_q - CNT_W'(1);
          ok_d     = 1'b1;
        end
      end
      rfdp_pkg::OP_DROP: begin
        rd_idx_d  = wrap_add(rd_idx_q, drop_n, cap);
        held_d    = held_q - drop_n;
        dropped_d = CMP_W'(drop_n) <= CMP_W'(31) ? 5'(drop_n) : 5'(drop_n);
        ok_d      = 1'b1;
      end
      rfdp_pkg::OP_PEEK: begin
        if (cnt_ext < held_ext) begin
          rd_sel_d = 1'b1;
          rd_addr  = peek_idx;
          ok_d     = 1'b1;
        end
      end
      default: begin
      end
    endcase
    held_d_ext = CMP_W'(held_d);
    free_n     = cap - held_d;
    free_ext   = CMP_W'(free_n);
    fill_d     = held_d_ext[rfdp_pkg::OUT_CNT_W-1:0];
    free_d     = free_ext[rfdp_pkg::OUT_CNT_W-1:0];
  end

  assign mem_re  = advance && rd_sel_d;
  assign din_ext = 64'(cmd_i.data);
  assign wr_word = din_ext[WORD_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_raw_q   <= rfdp_pkg::CFG_RESET;
      wr_idx_q    <= '0;
      rd_idx_q    <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        // A capacity write also empties the FIFO.
        cap_raw_q <= cfg_wdata_i;
        wr_idx_q  <= '0;
        rd_idx_q  <= '0;
        held_q    <= '0;
      end else if (advance) begin
        wr_idx_q <= wr_idx_d;
        rd_idx_q <= rd_idx_d;
        held_q   <= held_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ok_q      <= ok_d;
      rd_sel_q  <= rd_sel_d;
      dropped_q <= dropped_d;
      fill_q    <= fill_d;
      free_q    <= free_d;
    end
  end

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (advance && mem_we && !cfg_we_i) begin
      mem[wr_idx_q] <= wr_word;
    end
    if (mem_re) begin
      rd_word_q <= mem[rd_addr];
    end
  end

  assign rd_ext    = 64'(rd_word_q);
  assign m_valid_o = out_valid_q;
  assign m_user_o  = ok_q;
  assign m_data_o  = {1'b0, free_q, fill_q, dropped_q,
                      rd_sel_q ? rd_ext[rfdp_pkg::OUT_DATA_W-1:0] : '0};

  assert property (@(posedge clk_i) disable iff (!rst_ni) held_ext <= cap_ext)
    else $error("fill count exceeds capacity in use");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   CMP_W'(rd_idx_q) < cap_ext && CMP_W'(wr_idx_q) < cap_ext)
    else $error("ring index outside capacity in use");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   advance && !cfg_we_i && !ok_d |=> held_q == $past(held_q))
    else $error("refused command changed the fill count");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   advance && !cfg_we_i && cmd_i.op == rfdp_pkg::OP_DROP
                   |=> held_q <= $past(held_q))
    else $error("drop increased the fill count");

endmodule

// ===== src/ring_fifo_with_drop_and_peek.sv =====
// Top level of the ring FIFO with drop and peek: stream ports, front queue
// and back end. Depends on rfdp_pkg, rfdp_front and rfdp_back.
//
//  channel  direction  handshake                    payload
//  s_axis   in         s_axis_tvalid/s_axis_tready  tuser command, tdata data_in, count
//  m_axis   out        m_axis_tvalid/m_axis_tready  tuser ok, tdata data_out .. free_slots
//  cfg      in         cfg_we_i (no wait)           cfg_wdata_i capacity_in_use
//
// One item per cycle sustained while results are taken. m_axis_tvalid for a result rises once
// its item has passed the front queue and then the back end's result register.
// The rate is set by the one execute stage, which makes at most one slot access per item.
// Reset clears indexes and fill count at once; slot contents stay undefined.
// A stalled result holds the back end, and the two-entry front queue then
// fills and drops s_axis_tready.
module ring_fifo_with_drop_and_peek #(
  parameter int unsigned DEPTH     = rfdp_pkg::DEPTH_DEFAULT,
  parameter int unsigned WORD_BITS = rfdp_pkg::WORD_BITS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rfdp_pkg::CFG_W-1:0]        cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // data_in [31:0], count [36:32], zero fill [39:37]
  input  logic [rfdp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // command [1:0]
  input  logic [rfdp_pkg::CMD_W-1:0]        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // data_out [31:0], dropped [36:32], fill_level [41:37], free_slots [46:42], zero [47]
  output logic [rfdp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // ok [0]
  output logic                              m_axis_tuser
);

  logic           cmd_valid;
  logic           cmd_ready;
  rfdp_pkg::cmd_t cmd;

  rfdp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .s_user_i    (s_axis_tuser),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  rfdp_back #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .m_user_o    (m_axis_tuser)
  );

endmodule

// ===== tb/fifo_response_checker.sv =====
`timescale 1ns / 1ps
// Response checker for the ring FIFO with drop and peek. It watches the command, response and
// capacity channels, predicts every response and compares it. Depends on rfdp_pkg only.
module fifo_response_checker
  import rfdp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic                   cmd_valid_i,
  input  logic                   cmd_ready_i,
  input  logic [IN_TDATA_W-1:0]  cmd_data_i,
  input  logic [CMD_W-1:0]       cmd_user_i,
  input  logic                   rsp_valid_i,
  input  logic                   rsp_ready_i,
  input  logic [OUT_TDATA_W-1:0] rsp_data_i,
  input  logic                   rsp_user_i,
  output int                     fail_count_o,
  output int                     pending_o
);

  localparam int SLOTS = DEPTH_DEFAULT;

  typedef struct packed {
    logic                  ok;
    logic [OUT_DATA_W-1:0] word;
    logic [OUT_CNT_W-1:0]  dropped;
    logic [OUT_CNT_W-1:0]  fill;
    logic [OUT_CNT_W-1:0]  free;
  } response_t;

  response_t             due_responses[$];
  logic [IN_DATA_W-1:0]  slot_copy[SLOTS];
  int                    wr_pos;
  int                    rd_pos;
  int                    held;
  int                    cap_live;
  int                    fails;

  // A capacity of zero behaves as one slot, anything above the storage depth as the depth.
  function automatic int clamp_capacity(logic [CFG_W-1:0] value);
    if (value == 0) return 1;
    if (value > SLOTS) return SLOTS;
    return int'(value);
  endfunction

  function automatic int ring_add(int base, int add);
    int sum;
    sum = base + add;
    if (sum >= cap_live) sum -= cap_live;
    return sum;
  endfunction

  // Applies one command to the mirrored FIFO and returns the response it must produce.
  function automatic response_t predict_response(op_e op, logic [IN_DATA_W-1:0] din,
                                                 logic [COUNT_W-1:0] cnt);
    response_t rsp;
    int        n;
    rsp = '0;
    case (op)
      OP_PUSH: begin
        if (held < cap_live) begin
          slot_copy[wr_pos] = din;
          wr_pos = ring_add(wr_pos, 1);
          held++;
          rsp.ok = 1'b1;
        end
      end
      OP_POP: begin
        if (held > 0) begin
          rsp.word = slot_copy[rd_pos];
          rd_pos = ring_add(rd_pos, 1);
          held--;
          rsp.ok = 1'b1;
        end
      end
      OP_DROP: begin
        n = (int'(cnt) < held) ? int'(cnt) : held;
        rd_pos = ring_add(rd_pos, n);
        held -= n;
        rsp.dropped = OUT_CNT_W'(n);
        rsp.ok = 1'b1;
      end
      default: begin
        if (int'(cnt) < held) begin
          rsp.word = slot_copy[ring_add(rd_pos, int'(cnt))];
          rsp.ok = 1'b1;
        end
      end
    endcase
    rsp.fill = OUT_CNT_W'(held);
    rsp.free = OUT_CNT_W'(cap_live - held);
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    response_t got;
    response_t want;
    if (!rst_ni) begin
      due_responses.delete();
      wr_pos = 0;
      rd_pos = 0;
      held = 0;
      cap_live = clamp_capacity(CFG_RESET);
      fails = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        got = {rsp_user_i, rsp_data_i[31:0], rsp_data_i[36:32], rsp_data_i[41:37],
               rsp_data_i[46:42]};
        if (due_responses.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: response with none outstanding: ok=%0b data=%h", $realtime,
                     got.ok, got.word);
        end else begin
          want = due_responses.pop_front();
          if (got.ok !== want.ok || got.word !== want.word || got.dropped !== want.dropped ||
              got.fill !== want.fill || got.free !== want.free) begin
            fails++;
            if (fails <= 10) begin
              $display("%0t: response mismatch, expected ok=%0b data=%h dropped=%0d fill=%0d free=%0d",
                       $realtime, want.ok, want.word, want.dropped, want.fill, want.free);
              $display("    got ok=%0b data=%h dropped=%0d fill=%0d free=%0d",
                       got.ok, got.word, got.dropped, got.fill, got.free);
            end
          end
        end
      end
      // A capacity write also empties the FIFO; the words stay but are unreachable.
      if (cfg_we_i) begin
        cap_live = clamp_capacity(cfg_wdata_i);
        wr_pos = 0;
        rd_pos = 0;
        held = 0;
      end
      if (cmd_valid_i && cmd_ready_i)
        due_responses.push_back(predict_response(op_e'(cmd_user_i), cmd_data_i[31:0],
                                                 cmd_data_i[36:32]));
    end
    pending_o <= due_responses.size();
    fail_count_o <= fails;
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the testbench for ring_fifo_with_drop_and_peek: clock, reset, command stimulus,
// response back-pressure and the verdict. Depends on rfdp_pkg, ring_fifo_with_drop_and_peek and fifo_response_checker.
module testbench;
  import rfdp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 40;
  localparam int PHASE_ITEMS = 75;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_W-1:0]       cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [CMD_W-1:0]       s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  int fail_count;
  int pending;
  int cycles;
  int src_idle_pct;
  int sink_idle_pct;
  bit hold_req;

  logic [CFG_W-1:0] phase_caps[8] = '{5'd31, 5'd1, 5'd5, 5'd16, 5'd9, 5'd20, 5'd3, 5'd12};

  ring_fifo_with_drop_and_peek dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  fifo_response_checker fifo_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_valid_i  (s_axis_tvalid),
    .cmd_ready_i  (s_axis_tready),
    .cmd_data_i   (s_axis_tdata),
    .cmd_user_i   (s_axis_tuser),
    .rsp_valid_i  (m_axis_tvalid),
    .rsp_ready_i  (m_axis_tready),
    .rsp_data_i   (m_axis_tdata),
    .rsp_user_i   (m_axis_tuser),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

  // Response side: random stalls, plus one long hold-off when the stimulus asks for it.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
        @(posedge clk_i);
      end
    end
  end

  // Offers one command and returns right after the edge at which it was taken.
  task automatic send_item(op_e op, logic [IN_DATA_W-1:0] din, logic [COUNT_W-1:0] cnt);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, cnt, din};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Stops offering and waits until every outstanding response has been taken.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [CFG_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int unsigned roll;
    logic [COUNT_W-1:0] cnt;
    op_e op;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OP_PUSH;
    hold_req      = 1'b0;
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed commands at the reset capacity: empty refusals, extreme words and counts.
    send_item(OP_POP,  32'h0, 5'd0);
    send_item(OP_PEEK, 32'h0, 5'd0);
    send_item(OP_DROP, 32'h0, 5'd5);
    send_item(OP_PUSH, 32'h0000_0000, 5'd0);
    send_item(OP_PUSH, 32'hFFFF_FFFF, 5'd31);
    send_item(OP_PUSH, 32'hA5A5_A5A5, 5'd0);
    send_item(OP_PEEK, 32'h0, 5'd0);
    send_item(OP_PEEK, 32'h0, 5'd2);
    send_item(OP_PEEK, 32'h0, 5'd3);
    send_item(OP_PEEK, 32'h0, 5'd15);
    send_item(OP_PEEK, 32'h0, 5'd16);
    send_item(OP_DROP, 32'h0, 5'd0);
    send_item(OP_POP,  32'h0, 5'd0);
    send_item(OP_DROP, 32'h0, 5'd16);
    drain();

    // A zero capacity acts as a single slot: second push is refused as full.
    write_capacity(5'd0);
    send_item(OP_PUSH, 32'h1234_5678, 5'd0);
    send_item(OP_PUSH, 32'h9ABC_DEF0, 5'd0);
    send_item(OP_PEEK, 32'h0, 5'd0);
    send_item(OP_POP,  32'h0, 5'd0);
    send_item(OP_POP,  32'h0, 5'd0);
    // Words pushed before a capacity write must not be reachable afterwards.
    send_item(OP_PUSH, 32'h0BAD_F00D, 5'd0);
    drain();
    write_capacity(5'd16);
    send_item(OP_PEEK, 32'h0, 5'd0);
    send_item(OP_POP,  32'h0, 5'd0);
    drain();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 3)
        0: begin src_idle_pct = 29; sink_idle_pct = 60; end
        1: begin src_idle_pct = 60; sink_idle_pct = 29; end
        default: begin src_idle_pct = 0; sink_idle_pct = 0; end
      endcase
      write_capacity(phase_caps[phase]);
      if (phase == 3) hold_req = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (phase == 4 && i == PHASE_ITEMS / 2) drain();
        roll = $urandom_range(0, 99);
        if (roll < 40) op = OP_PUSH;
        else if (roll < 65) op = OP_POP;
        else if (roll < 78) op = OP_DROP;
        else op = OP_PEEK;
        if ($urandom_range(0, 99) < 70)
          cnt = COUNT_W'($urandom_range(0, (op == OP_DROP) ? 3 : 5));
        else
          cnt = COUNT_W'($urandom_range(0, 16));
        send_item(op, $urandom, cnt);
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
